FILE: rtl/abs_sorted_to_sorted_top_assert.svh
// assertion macros for the abs_sorted_to_sorted rtl
// no dependencies; included by modules that check their own logic
`ifndef ABS_SORTED_TO_SORTED_TOP_ASSERT_SVH
`define ABS_SORTED_TO_SORTED_TOP_ASSERT_SVH

// same-cycle implication
`define ABSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/abss_pkg.sv
// shared types and constants for the abs_sorted_to_sorted block
// no dependencies
package abss_pkg;

    localparam int DEF_MAX_ITEMS  = 64;
    localparam int DEF_VALUE_BITS = 32;
    localparam int IN_BITS        = 32;
    localparam int OUT_BITS       = 32;
    localparam int QUEUE_DEPTH    = 2;

    typedef struct packed {
        logic signed [IN_BITS-1:0] value;
        logic                      last_item;
    } t_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] sorted_value;
        logic                       run_end;
        logic                       overflowed;
    } t_out;

    typedef logic [1:0] t_op_kind;

    localparam t_op_kind OP_KEPT  = 2'd0;
    localparam t_op_kind OP_FRONT = 2'd1;
    localparam t_op_kind OP_DROP  = 2'd2;

    typedef struct packed {
        t_op_kind kind;
        logic     closing;
        logic     overflowed;
    } t_op_ctl;

    localparam int OP_CTL_BITS = $bits(t_op_ctl);

endpackage

FILE: rtl/abss_front.sv
// front end: takes input items and sorts each into kept, front-stack or dropped
// depends on abss_pkg
module abss_front #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  abss_pkg::t_in          i_in_item,
    output logic                   o_op_valid,
    input  logic                   i_op_stall,
    output abss_pkg::t_op_ctl      o_op_ctl,
    output logic [VALUE_BITS-1:0]  o_op_value
);
    import abss_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0]                r_total;
    logic [CW-1:0]                n_total;
    logic                         r_have_kept;
    logic                         n_have_kept;
    logic signed [VALUE_BITS-1:0] r_last_kept;
    logic signed [VALUE_BITS-1:0] n_last_kept;
    logic                         r_drop;
    logic                         n_drop;

    logic signed [VALUE_BITS-1:0] w_value;
    t_op_kind                     w_kind;
    logic                         w_accept;

    assign w_value    = VALUE_BITS'(i_in_item.value);
    assign w_accept   = i_in_valid && !i_op_stall;
    assign o_op_valid = i_in_valid;
    assign o_in_stall = i_op_stall;

    always_comb begin
        priority if (r_total >= CW'(MAX_ITEMS)) begin
            w_kind = OP_DROP;
        end else if (!r_have_kept) begin
            w_kind = OP_KEPT;
        end else if (w_value < r_last_kept) begin
            w_kind = OP_FRONT;
        end else begin
            w_kind = OP_KEPT;
        end
    end

    assign o_op_ctl.kind       = w_kind;
    assign o_op_ctl.closing    = i_in_item.last_item;
    assign o_op_ctl.overflowed = r_drop || (w_kind == OP_DROP);
    assign o_op_value          = w_value;

    always_comb begin
        n_total     = r_total;
        n_have_kept = r_have_kept;
        n_last_kept = r_last_kept;
        n_drop      = r_drop;
        if (w_accept) begin
            if (i_in_item.last_item) begin
                // list ends here, start afresh for the next one
                n_total     = '0;
                n_have_kept = 1'b0;
                n_last_kept = '0;
                n_drop      = 1'b0;
            end else begin
                unique case (w_kind)
                    OP_KEPT: begin
                        n_total     = r_total + CW'(1);
                        n_have_kept = 1'b1;
                        n_last_kept = w_value;
                    end
                    OP_FRONT: begin
                        n_total = r_total + CW'(1);
                    end
                    default: begin
                        n_drop = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_have_kept <= 1'b0;
            r_last_kept <= '0;
            r_drop      <= 1'b0;
        end else begin
            r_total     <= n_total;
            r_have_kept <= n_have_kept;
            r_last_kept <= n_last_kept;
            r_drop      <= n_drop;
        end
    end

endmodule

FILE: rtl/abss_queue.sv
// short fifo between front and back ends
// depends on abss_pkg for its depth
module abss_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_stall,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data
);
    import abss_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_slot [QUEUE_DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [NW-1:0]    r_cnt;
    logic [NW-1:0]    n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_push_stall = (r_cnt == NW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_slot[r_rp];
    assign w_push       = i_push_valid && !o_push_stall;
    assign w_pop        = i_pop && o_pop_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
        end
    end

endmodule

FILE: rtl/abss_back.sv
// back end: stores classified items and plays the sorted run out
// depends on abss_pkg and abs_sorted_to_sorted_top_assert.svh
`include "abs_sorted_to_sorted_top_assert.svh"

module abss_back #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_op_valid,
    output logic                  o_op_pop,
    input  abss_pkg::t_op_ctl     i_op_ctl,
    input  logic [VALUE_BITS-1:0] i_op_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output abss_pkg::t_out        o_out_item
);
    import abss_pkg::*;

    localparam int CW       = $clog2(MAX_ITEMS + 1);
    localparam int IW       = $clog2(MAX_ITEMS);
    localparam int EXT_BITS = (VALUE_BITS > OUT_BITS) ? VALUE_BITS : OUT_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PREP  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [CW-1:0]         r_fcnt;
    logic [CW-1:0]         n_fcnt;
    logic [CW-1:0]         r_kcnt;
    logic [CW-1:0]         n_kcnt;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         n_idx;
    logic                  r_phase;
    logic                  n_phase;
    logic                  r_ovf;
    logic                  n_ovf;

    logic [VALUE_BITS-1:0] r_front_mem [MAX_ITEMS];
    logic [VALUE_BITS-1:0] r_kept_mem  [MAX_ITEMS];
    logic [VALUE_BITS-1:0] r_qf;
    logic [VALUE_BITS-1:0] r_qk;

    logic                         w_pop;
    logic                         w_take;
    logic                         w_kept_last;
    logic signed [VALUE_BITS-1:0] w_q;
    logic signed [EXT_BITS-1:0]   w_ext;

    assign w_pop       = (r_state == ST_IDLE) && i_op_valid;
    assign o_op_pop    = w_pop;
    assign o_out_valid = (r_state == ST_DRAIN);
    assign w_take      = o_out_valid && !i_out_stall;
    assign w_kept_last = !r_phase && (CW'(r_idx) == (r_kcnt - CW'(1)));

    always_comb begin
        n_state = r_state;
        n_fcnt  = r_fcnt;
        n_kcnt  = r_kcnt;
        n_idx   = r_idx;
        n_phase = r_phase;
        n_ovf   = r_ovf;
        unique case (r_state)
            ST_IDLE: begin
                if (w_pop) begin
                    unique case (i_op_ctl.kind)
                        OP_FRONT: n_fcnt = r_fcnt + CW'(1);
                        OP_KEPT:  n_kcnt = r_kcnt + CW'(1);
                        default:  ;
                    endcase
                    if (i_op_ctl.closing) begin
                        n_state = ST_PREP;
                        n_ovf   = i_op_ctl.overflowed;
                    end
                end
            end
            ST_PREP: begin
                // front stack comes out newest first
                if (r_fcnt != '0) begin
                    n_phase = 1'b1;
                    n_idx   = IW'(r_fcnt - CW'(1));
                end else begin
                    n_phase = 1'b0;
                    n_idx   = '0;
                end
                n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (w_take) begin
                    if (r_phase) begin
                        if (r_idx == '0) begin
                            n_phase = 1'b0;
                        end else begin
                            n_idx = r_idx - IW'(1);
                        end
                    end else if (w_kept_last) begin
                        n_state = ST_IDLE;
                        n_fcnt  = '0;
                        n_kcnt  = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // read at the next index so the registered data lines up with r_idx
    always_ff @(posedge i_clk) begin
        if (w_pop && (i_op_ctl.kind == OP_FRONT)) begin
            r_front_mem[r_fcnt[IW-1:0]] <= i_op_value;
        end
        r_qf <= r_front_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && (i_op_ctl.kind == OP_KEPT)) begin
            r_kept_mem[r_kcnt[IW-1:0]] <= i_op_value;
        end
        r_qk <= r_kept_mem[n_idx];
    end

    assign w_q   = r_phase ? r_qf : r_qk;
    assign w_ext = EXT_BITS'(w_q);

    assign o_out_item.sorted_value = w_ext[OUT_BITS-1:0];
    assign o_out_item.run_end      = w_kept_last;
    assign o_out_item.overflowed   = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fcnt  <= '0;
            r_kcnt  <= '0;
            r_idx   <= '0;
            r_phase <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fcnt  <= n_fcnt;
            r_kcnt  <= n_kcnt;
            r_idx   <= n_idx;
            r_phase <= n_phase;
            r_ovf   <= n_ovf;
        end
    end

    `ABSS_ASSERT_IMP(a_no_pop_busy, i_clk, i_rst_n, r_state != ST_IDLE, !o_op_pop, "queue popped while playing out")
    `ABSS_ASSERT_IMP(a_kept_present, i_clk, i_rst_n, o_out_valid, r_kcnt != '0, "run with empty kept buffer")
    `ABSS_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, ({1'b0, r_fcnt} + {1'b0, r_kcnt}) <= (CW+1)'(MAX_ITEMS), "stored items exceed capacity")
    `ABSS_ASSERT_NEXT(a_run_closes, i_clk, i_rst_n, w_take && o_out_item.run_end, !o_out_valid && (r_fcnt == '0) && (r_kcnt == '0), "run end did not clear state")

endmodule

FILE: rtl/abs_sorted_to_sorted_top.sv
// Reorders a list sorted by absolute value into ascending signed order. Each
// input item is classified combinationally by the front end, passes through a
// two-entry queue and is written to the front stack or kept buffer by the back
// end while it is idle. The item marked last_item starts the play-out: a setup
// state (ST_PREP), then one result per cycle while the receiver does not stall
// (front stack newest first, then kept buffer); each buffer has a single read
// port. Items past MAX_ITEMS are dropped and overflowed is set on every result
// of that run. Depends on abss_pkg, abss_front, abss_queue, abss_back.
module abs_sorted_to_sorted_top #(
    parameter int MAX_ITEMS  = abss_pkg::DEF_MAX_ITEMS,
    parameter int VALUE_BITS = abss_pkg::DEF_VALUE_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  abss_pkg::t_in  i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output abss_pkg::t_out o_out_item
);
    import abss_pkg::*;

    localparam int QW = OP_CTL_BITS + VALUE_BITS;

    logic                  w_op_valid;
    logic                  w_op_stall;
    t_op_ctl               w_op_ctl;
    logic [VALUE_BITS-1:0] w_op_value;
    logic [QW-1:0]         w_push_data;
    logic                  w_q_valid;
    logic                  w_q_pop;
    logic [QW-1:0]         w_q_data;
    t_op_ctl               w_q_ctl;
    logic [VALUE_BITS-1:0] w_q_value;

    assign w_push_data = {w_op_ctl, w_op_value};
    assign w_q_ctl     = w_q_data[QW-1:VALUE_BITS];
    assign w_q_value   = w_q_data[VALUE_BITS-1:0];

    abss_front #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_op_valid (w_op_valid),
        .i_op_stall (w_op_stall),
        .o_op_ctl   (w_op_ctl),
        .o_op_value (w_op_value)
    );

    abss_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_op_valid),
        .o_push_stall (w_op_stall),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_q_valid),
        .i_pop        (w_q_pop),
        .o_pop_data   (w_q_data)
    );

    abss_back #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (w_q_valid),
        .o_op_pop    (w_q_pop),
        .i_op_ctl    (w_q_ctl),
        .i_op_value  (w_q_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: tb/abs_sorted_to_sorted_top_tb.sv
// testbench for abs_sorted_to_sorted_top: drives lists sorted by magnitude, plus
// random lists, and checks each played-out item against an in-bench predictor
// depends on abss_pkg and the abs_sorted_to_sorted rtl
module abs_sorted_to_sorted_top_tb;
    import abss_pkg::*;

    localparam int CAPACITY     = DEF_MAX_ITEMS;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;
    localparam int PHASE_ITEMS  = 8;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_in  i_in_item   = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_item;

    always #10 i_clk = ~i_clk;

    abs_sorted_to_sorted_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // predictor state
    logic signed [IN_BITS-1:0] front_stack[$];
    logic signed [IN_BITS-1:0] kept_run[$];
    logic signed [IN_BITS-1:0] last_kept = '0;
    logic                      drop_seen = 1'b0;
    t_out                      awaited_sorted[$];

    int mismatches    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int out_hold_left = 0;
    int list_items    = 0;

    // files one accepted item; the closing item plays out the whole list
    task automatic sort_step(input t_in item);
        t_out res;
        if (front_stack.size() + kept_run.size() >= CAPACITY) begin
            drop_seen = 1'b1;
        end else if (kept_run.size() == 0) begin
            kept_run.push_back(item.value);
            last_kept = item.value;
        end else if ($signed(item.value) < $signed(last_kept)) begin
            front_stack.push_back(item.value);
        end else begin
            kept_run.push_back(item.value);
            last_kept = item.value;
        end
        if (item.last_item) begin
            res.overflowed = drop_seen;
            res.run_end    = 1'b0;
            while (front_stack.size() != 0) begin
                res.sorted_value = front_stack.pop_back();
                awaited_sorted.push_back(res);
            end
            // the kept run is never empty here, so it always holds the end marker
            while (kept_run.size() != 0) begin
                res.run_end      = (kept_run.size() == 1);
                res.sorted_value = kept_run.pop_front();
                awaited_sorted.push_back(res);
            end
            last_kept = '0;
            drop_seen = 1'b0;
        end
    endtask

    task automatic send_item(input t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        list_items++;
        sort_step(item);
    endtask

    // random list; by_magnitude gives non-decreasing magnitudes with random signs
    task automatic send_list(input int n, input bit by_magnitude);
        t_in    item;
        longint mag;
        int     step_bits;
        step_bits = $urandom_range(0, 27);
        mag       = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
            if (by_magnitude) begin
                if ($urandom_range(3) != 0) begin
                    mag += $urandom_range(0, 1 << step_bits);
                end
                if (mag > 64'h8000_0000) begin
                    mag = 64'h8000_0000;
                end
                if ($urandom_range(1) == 1) begin
                    item.value = -mag[31:0];
                end else begin
                    item.value = (mag > 64'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
                end
            end else begin
                item.value = $urandom;
            end
            item.last_item = (k == n - 1);
            send_item(item);
        end
    endtask

    task automatic send_fixed(input int vals[$]);
        t_in item;
        foreach (vals[k]) begin
            item.value     = vals[k];
            item.last_item = (k == vals.size() - 1);
            send_item(item);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (awaited_sorted.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_single_items();
        send_fixed('{32'h7fff_ffff});
        send_fixed('{32'h8000_0000});
        send_fixed('{0});
        wait_drained();
    endtask

    // ties, equal magnitudes of both signs and both ends of the range
    task automatic test_extremes();
        send_fixed('{0, -1, 1, 1, -5, 7, -7, -2147483647, 32'h7fff_ffff, 32'h8000_0000});
        wait_drained();
    endtask

    // all but the first item on the front stack, then a list wholly in the kept run
    task automatic test_one_sided();
        send_fixed('{-1, -2, -3, -4});
        send_fixed('{1, 2, 3});
        wait_drained();
    endtask

    // a list that fills the buffers exactly, then drops its tail, closing item too
    task automatic test_capacity();
        send_list(CAPACITY + 2, 1'b1);
        wait_drained();
    endtask

    // long receiver hold-off while the next list keeps coming, so the input backs up
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_list(8, 1'b1);
        out_hold_left = 200;
        send_list(30, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall);
        int start;
        int n;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        start         = list_items;
        while (list_items - start < PHASE_ITEMS) begin
            n = $urandom_range(1, PHASE_ITEMS);
            send_list(n, $urandom_range(3) != 0);
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (out_hold_left > 0) begin
            i_out_stall <= 1'b1;
            out_hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_sorted.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: value %0d end %0b ovf %0b",
                             o_out_item.sorted_value, o_out_item.run_end,
                             o_out_item.overflowed);
                end
            end else begin
                want = awaited_sorted.pop_front();
                if (o_out_item !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected value %0d end %0b ovf %0b, got %0d %0b %0b",
                                 want.sorted_value, want.run_end, want.overflowed,
                                 o_out_item.sorted_value, o_out_item.run_end,
                                 o_out_item.overflowed);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_items();
        test_extremes();
        test_one_sided();
        test_capacity();
        test_random_phase(0, 0);
        test_random_phase(65, 0);
        test_random_phase(0, 65);
        test_random_phase(27, 27);
        test_backpressure();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited_sorted.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/abss_pkg.sv
rtl/abss_front.sv
rtl/abss_queue.sv
rtl/abss_back.sv
rtl/abs_sorted_to_sorted_top.sv
tb/abs_sorted_to_sorted_top_tb.sv
